[src/qrs_pkg.sv]
// shared constants and types for the quadratic root solver
package qrs_pkg;

  localparam int unsigned CoefW = 16;                 // coefficient width
  localparam int unsigned FracW = 16;                 // root fraction bits
  localparam int unsigned RootW = 34;                 // root field width
  localparam int unsigned DiscW = 2 * CoefW + 2;      // discriminant magnitude
  localparam int unsigned SqrtW = CoefW + 1 + FracW;  // square root result
  localparam int unsigned RadW  = 2 * SqrtW;          // scaled radicand
  localparam int unsigned NumW  = SqrtW + 1;          // dividend magnitude
  localparam int unsigned DenW  = CoefW + 1;          // divisor magnitude

  typedef enum logic [2:0] {
    ST_TWO  = 3'd0,
    ST_ONE  = 3'd1,
    ST_LIN  = 3'd2,
    ST_CPLX = 3'd3,
    ST_NONE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    K_NONE,
    K_LIN,
    K_SHORT,
    K_DISC
  } kind_e;

  typedef enum logic [1:0] {
    D_NEG,
    D_ZERO,
    D_POS
  } dcls_e;

  // per-item sideband from classification through the square root
  typedef struct packed {
    logic [CoefW-1:0] a;
    logic [CoefW-1:0] b;
    logic [CoefW-1:0] c;
    kind_e            kind;
    logic             neg_one;
    dcls_e            dcls;
  } front_t;

  // per-item sideband through the dividers
  typedef struct packed {
    status_e st;
    logic    cmp;
  } dside_t;

  // one division job: magnitudes and sign of the quotient
  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
    logic            neg;
  } lane_t;

endpackage

[src/qrs_if.sv]
// handshake channel interfaces for coefficients and roots
interface qrs_coef_if;
  import qrs_pkg::*;
  logic             valid;
  logic             ready;
  logic [CoefW-1:0] coef_sq;
  logic [CoefW-1:0] coef_lin;
  logic [CoefW-1:0] coef_const;

  modport source (output valid, coef_sq, coef_lin, coef_const, input ready);
  modport sink (input valid, coef_sq, coef_lin, coef_const, output ready);
endinterface

interface qrs_root_if;
  import qrs_pkg::*;
  logic             valid;
  logic             ready;
  status_e          status;
  logic [RootW-1:0] root_first;
  logic [RootW-1:0] root_second;

  modport source (output valid, status, root_first, root_second, input ready);
  modport sink (input valid, status, root_first, root_second, output ready);
endinterface

[src/quadratic_root_solver_core.sv]
// top level of the quadratic root solver pipeline
//
// coef_i carries the signed integer coefficients a, b, c of a*x^2+b*x+c=0;
// root_o returns a status and two signed Q17.16 roots, one transaction per
// coefficient set, in order. Both channels use valid/ready; a transaction
// moves when both are high.
// The pipeline runs, in order, through the product and discriminant
// registers, the square root stages (one result bit per stage), the
// dividend register, the two parallel dividers (one quotient bit per
// stage) and the output register.
// Throughput is one transaction per cycle while the output does not stall;
// every stage is a plain pipeline register with a valid bit.
// When root_o.ready is low while a result waits, the whole pipeline holds
// and coef_i.ready goes low; nothing is lost or repeated. coef_i.ready
// stays high while the output register is empty or being drained.
// Reset clears all valid bits; the pipeline is empty and ready right away.
module quadratic_root_solver_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  qrs_coef_if.sink   coef_i,
  qrs_root_if.source root_o
);
  import qrs_pkg::*;

  logic             en;
  logic             fr_v, sq_v, dv_v;
  front_t           fr_side, sq_side;
  logic [DiscW-1:0] fr_disc;
  logic [SqrtW-1:0] sq_root;

  dside_t           p_side_d, p_side_q, dv_side;
  lane_t [1:0]      p_lane_d, p_lane_q;
  logic             p_v_q;
  logic [1:0][NumW-1:0] dv_quo;
  logic [1:0]       dv_neg;

  logic             out_v_q;
  status_e          out_st_q;
  logic [RootW-1:0] out_r1_q, out_r2_q;

  // global advance: hold everything while a result is stuck at the output
  assign en           = !out_v_q || root_o.ready;
  assign coef_i.ready = en;

  qrs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (coef_i.valid),
    .a_i     (coef_i.coef_sq),
    .b_i     (coef_i.coef_lin),
    .c_i     (coef_i.coef_const),
    .valid_o (fr_v),
    .side_o  (fr_side),
    .disc_o  (fr_disc)
  );

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .side_i  (fr_side),
    .disc_i  (fr_disc),
    .valid_o (sq_v),
    .side_o  (sq_side),
    .root_o  (sq_root)
  );

  // form dividends and divisors for each case
  always_comb begin
    logic [CoefW-1:0]  a_mag, b_mag, c_mag;
    logic              a_neg, c_pos;
    logic [NumW-1:0]   c_sh;
    logic signed [NumW:0] nb, n1, n2;
    a_mag = sq_side.a[CoefW-1] ? CoefW'(-sq_side.a) : sq_side.a;
    b_mag = sq_side.b[CoefW-1] ? CoefW'(-sq_side.b) : sq_side.b;
    c_mag = sq_side.c[CoefW-1] ? CoefW'(-sq_side.c) : sq_side.c;
    a_neg = sq_side.a[CoefW-1];
    c_pos = !sq_side.c[CoefW-1] && (sq_side.c != '0);
    c_sh  = NumW'(c_mag) << FracW;
    nb    = -($signed({{(NumW+1-CoefW){sq_side.b[CoefW-1]}}, sq_side.b}) <<< FracW);
    n1    = nb + $signed({1'b0, sq_root});
    n2    = nb - $signed({1'b0, sq_root});
    p_side_d.st  = ST_NONE;
    p_side_d.cmp = 1'b0;
    for (int l = 0; l < 2; l++) begin
      p_lane_d[l].num = '0;
      p_lane_d[l].den = DenW'(1);
      p_lane_d[l].neg = 1'b0;
    end
    case (sq_side.kind)
      K_LIN: begin
        p_side_d.st = ST_LIN;
        for (int l = 0; l < 2; l++) begin
          p_lane_d[l].num = c_sh;
          p_lane_d[l].den = DenW'(b_mag);
          p_lane_d[l].neg = c_pos ^ sq_side.b[CoefW-1];
        end
      end
      K_SHORT: begin
        p_side_d.st     = ST_TWO;
        p_side_d.cmp    = 1'b1;
        p_lane_d[0].num = NumW'(1) << FracW;
        p_lane_d[0].neg = sq_side.neg_one;
        p_lane_d[1].num = c_sh;
        p_lane_d[1].den = DenW'(a_mag);
        p_lane_d[1].neg = sq_side.neg_one ? (c_pos ^ a_neg)
                                          : (sq_side.c[CoefW-1] ^ a_neg);
      end
      K_DISC: begin
        case (sq_side.dcls)
          D_POS: begin
            p_side_d.st     = ST_TWO;
            p_lane_d[0].num = n1[NumW] ? NumW'(-n1) : n1[NumW-1:0];
            p_lane_d[0].neg = n1[NumW] ^ a_neg;
            p_lane_d[1].num = n2[NumW] ? NumW'(-n2) : n2[NumW-1:0];
            p_lane_d[1].neg = n2[NumW] ^ a_neg;
            for (int l = 0; l < 2; l++) begin
              p_lane_d[l].den = {a_mag, 1'b0};
            end
          end
          D_ZERO: begin
            p_side_d.st = ST_ONE;
            for (int l = 0; l < 2; l++) begin
              p_lane_d[l].num = nb[NumW] ? NumW'(-nb) : nb[NumW-1:0];
              p_lane_d[l].neg = nb[NumW] ^ a_neg;
              p_lane_d[l].den = {a_mag, 1'b0};
            end
          end
          default: begin
            p_side_d.st = ST_CPLX;
          end
        endcase
      end
      default: begin
        p_side_d.st = ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_side_q <= p_side_d;
      p_lane_q <= p_lane_d;
    end
  end

  qrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_v_q),
    .side_i  (p_side_q),
    .lanes_i (p_lane_q),
    .valid_o (dv_v),
    .side_o  (dv_side),
    .quo_o   (dv_quo),
    .neg_o   (dv_neg)
  );

  // apply signs, saturate and settle the status of the shortcut cases
  logic [NumW:0]    q_s [2];
  logic [RootW-1:0] r_sat [2];
  status_e          st_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q_s[l] = dv_neg[l] ? (NumW+1)'(-{1'b0, dv_quo[l]}) : {1'b0, dv_quo[l]};
      if (q_s[l][NumW:RootW-1] == {(NumW-RootW+2){q_s[l][NumW]}}) begin
        r_sat[l] = q_s[l][RootW-1:0];
      end else begin
        r_sat[l] = {q_s[l][NumW], {(RootW-1){!q_s[l][NumW]}}};
      end
    end
    if (dv_side.cmp) begin
      st_d = (q_s[0] == q_s[1]) ? ST_ONE : ST_TWO;
    end else begin
      st_d = dv_side.st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_st_q <= st_d;
      out_r1_q <= r_sat[0];
      out_r2_q <= r_sat[1];
    end
  end

  assign root_o.valid       = out_v_q;
  assign root_o.status      = out_st_q;
  assign root_o.root_first  = out_r1_q;
  assign root_o.root_second = out_r2_q;
endmodule

[src/qrs_front.sv]
// classification, products and discriminant: two register stages
module qrs_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [qrs_pkg::CoefW-1:0] a_i,
  input  logic [qrs_pkg::CoefW-1:0] b_i,
  input  logic [qrs_pkg::CoefW-1:0] c_i,
  output logic                      valid_o,
  output qrs_pkg::front_t           side_o,
  output logic [qrs_pkg::DiscW-1:0] disc_o
);
  import qrs_pkg::*;

  logic [CoefW-1:0]   a_mag, b_mag, c_mag;
  logic [CoefW:0]     sum_ac;
  logic [CoefW+1:0]   sum_abc;
  logic               hit_neg, hit_pos;
  front_t             side1_d, side1_q, side2_d, side2_q;
  logic [2*CoefW-1:0] m_q, b2_q;
  logic               pp_q, v1_q, v2_q;
  logic [DiscW-1:0]   fl, b2e, disc_d, disc_q;

  // stage one: shortcut tests and the two products
  always_comb begin
    a_mag   = a_i[CoefW-1] ? CoefW'(-a_i) : a_i;
    b_mag   = b_i[CoefW-1] ? CoefW'(-b_i) : b_i;
    c_mag   = c_i[CoefW-1] ? CoefW'(-c_i) : c_i;
    sum_ac  = {a_i[CoefW-1], a_i} + {c_i[CoefW-1], c_i};
    sum_abc = {{2{a_i[CoefW-1]}}, a_i} + {{2{b_i[CoefW-1]}}, b_i}
            + {{2{c_i[CoefW-1]}}, c_i};
    hit_neg = (sum_ac == {b_i[CoefW-1], b_i});
    hit_pos = (sum_abc == '0);
    side1_d.a       = a_i;
    side1_d.b       = b_i;
    side1_d.c       = c_i;
    side1_d.neg_one = hit_neg;
    side1_d.dcls    = D_NEG;
    if (a_i == '0) begin
      side1_d.kind = (b_i == '0) ? K_NONE : K_LIN;
    end else if (hit_neg || hit_pos) begin
      side1_d.kind = K_SHORT;
    end else begin
      side1_d.kind = K_DISC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side1_d;
      m_q     <= a_mag * c_mag;
      b2_q    <= b_mag * b_mag;
      pp_q    <= (a_i[CoefW-1] == c_i[CoefW-1]) && (a_i != '0) && (c_i != '0);
    end
  end

  // stage two: discriminant b*b - 4*a*c as a magnitude and a sign class
  always_comb begin
    fl      = {m_q, 2'b00};
    b2e     = DiscW'(b2_q);
    side2_d = side1_q;
    disc_d  = '0;
    if (!pp_q) begin
      disc_d       = b2e + fl;
      side2_d.dcls = (disc_d != '0) ? D_POS : D_ZERO;
    end else if (b2e > fl) begin
      disc_d       = b2e - fl;
      side2_d.dcls = D_POS;
    end else if (b2e == fl) begin
      side2_d.dcls = D_ZERO;
    end else begin
      side2_d.dcls = D_NEG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side2_q <= side2_d;
      disc_q  <= disc_d;
    end
  end

  assign valid_o = v2_q;
  assign side_o  = side2_q;
  assign disc_o  = disc_q;
endmodule

[src/qrs_sqrt.sv]
// pipelined digit-by-digit square root, one result bit per stage
module qrs_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  qrs_pkg::front_t           side_i,
  input  logic [qrs_pkg::DiscW-1:0] disc_i,
  output logic                      valid_o,
  output qrs_pkg::front_t           side_o,
  output logic [qrs_pkg::SqrtW-1:0] root_o
);
  import qrs_pkg::*;

  logic [RadW-1:0]  rad_q  [SqrtW];
  logic [SqrtW-1:0] root_q [SqrtW];
  logic [SqrtW+1:0] rem_q  [SqrtW];
  front_t           side_q [SqrtW];
  logic             v_q    [SqrtW];

  logic [RadW-1:0]  rad_nx  [SqrtW];
  logic [SqrtW-1:0] root_nx [SqrtW];
  logic [SqrtW+1:0] rem_nx  [SqrtW];

  // one iteration per stage: bring down a bit pair and try the subtract
  always_comb begin
    logic [RadW-1:0]  src_rad;
    logic [SqrtW-1:0] src_root;
    logic [SqrtW+1:0] src_rem, rem_sh, trial;
    for (int k = 0; k < SqrtW; k++) begin
      if (k == 0) begin
        src_rad  = {disc_i, {(2 * FracW){1'b0}}};
        src_root = '0;
        src_rem  = '0;
      end else begin
        src_rad  = rad_q[k-1];
        src_root = root_q[k-1];
        src_rem  = rem_q[k-1];
      end
      rem_sh    = {src_rem[SqrtW-1:0], src_rad[RadW-1 -: 2]};
      trial     = {src_root, 2'b01};
      rad_nx[k] = src_rad << 2;
      if (rem_sh >= trial) begin
        rem_nx[k]  = rem_sh - trial;
        root_nx[k] = {src_root[SqrtW-2:0], 1'b1};
      end else begin
        rem_nx[k]  = rem_sh;
        root_nx[k] = {src_root[SqrtW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SqrtW; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k < SqrtW; k++) begin
        v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SqrtW; k++) begin
        rad_q[k]  <= rad_nx[k];
        root_q[k] <= root_nx[k];
        rem_q[k]  <= rem_nx[k];
        side_q[k] <= (k == 0) ? side_i : side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[SqrtW-1];
  assign side_o  = side_q[SqrtW-1];
  assign root_o  = root_q[SqrtW-1];
endmodule

[src/qrs_div.sv]
// two-lane pipelined restoring divider, one quotient bit per stage
module qrs_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  qrs_pkg::dside_t                     side_i,
  input  qrs_pkg::lane_t [1:0]                lanes_i,
  output logic                                valid_o,
  output qrs_pkg::dside_t                     side_o,
  output logic [1:0][qrs_pkg::NumW-1:0]       quo_o,
  output logic [1:0]                          neg_o
);
  import qrs_pkg::*;

  logic [NumW-1:0] nq_q  [NumW][2];
  logic [DenW-1:0] rem_q [NumW][2];
  logic [DenW-1:0] den_q [NumW][2];
  logic            neg_q [NumW][2];
  dside_t          side_q [NumW];
  logic            v_q    [NumW];

  logic [NumW-1:0] nq_nx  [NumW][2];
  logic [DenW-1:0] rem_nx [NumW][2];

  // shift in one dividend bit and subtract the divisor where it fits
  always_comb begin
    logic [NumW-1:0] src_nq;
    logic [DenW-1:0] src_rem, src_den;
    logic [DenW:0]   rem_sh;
    for (int k = 0; k < NumW; k++) begin
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          src_nq  = lanes_i[l].num;
          src_rem = '0;
          src_den = lanes_i[l].den;
        end else begin
          src_nq  = nq_q[k-1][l];
          src_rem = rem_q[k-1][l];
          src_den = den_q[k-1][l];
        end
        rem_sh = {src_rem, src_nq[NumW-1]};
        if (rem_sh >= {1'b0, src_den}) begin
          rem_nx[k][l] = DenW'(rem_sh - {1'b0, src_den});
          nq_nx[k][l]  = {src_nq[NumW-2:0], 1'b1};
        end else begin
          rem_nx[k][l] = rem_sh[DenW-1:0];
          nq_nx[k][l]  = {src_nq[NumW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumW; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      for (int k = 0; k < NumW; k++) begin
        v_q[k] <= (k == 0) ? valid_i : v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NumW; k++) begin
        side_q[k] <= (k == 0) ? side_i : side_q[k-1];
        for (int l = 0; l < 2; l++) begin
          nq_q[k][l]  <= nq_nx[k][l];
          rem_q[k][l] <= rem_nx[k][l];
          den_q[k][l] <= (k == 0) ? lanes_i[l].den : den_q[k-1][l];
          neg_q[k][l] <= (k == 0) ? lanes_i[l].neg : neg_q[k-1][l];
        end
      end
    end
  end

  assign valid_o = v_q[NumW-1];
  assign side_o  = side_q[NumW-1];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quo_o[l] = nq_q[NumW-1][l];
      neg_o[l] = neg_q[NumW-1][l];
    end
  end
endmodule

[tb/sv/tb_quadratic_root_solver_core.sv]
// testbench for the quadratic root solver core: random and directed coefficient sets
`timescale 1ns / 100ps

module tb_quadratic_root_solver_core;
  import qrs_pkg::*;

  typedef struct {
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
  } coef_set_t;

  typedef struct {
    status_e          st;
    logic [RootW-1:0] r1;
    logic [RootW-1:0] r2;
  } roots_t;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles   = 150;
  localparam int unsigned QuietStart    = 50;
  localparam int unsigned QuietEnd      = 300;

  logic clk_i;
  logic rst_ni;

  qrs_coef_if coef_if ();
  qrs_root_if root_if ();

  quadratic_root_solver_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef_if.sink),
    .root_o (root_if.source)
  );

  coef_set_t   pending_sets[$];
  roots_t      expected_roots[$];
  coef_set_t   offered_set;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned results_seen;
  int unsigned idle_cnt;
  int unsigned hold_cnt;
  bit          hold_done;

  // clock and reset
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    coef_if.valid = 1'b0;
    coef_if.coef_sq = '0;
    coef_if.coef_lin = '0;
    coef_if.coef_const = '0;
    root_if.ready = 1'b0;
    repeat (5) begin
      #5 clk_i = 1'b1;
      #5 clk_i = 1'b0;
    end
    rst_ni = 1'b1;
    forever #5 clk_i = ~clk_i;
  end

  // floor(sqrt(d * 2^32)), one result bit per step
  function automatic longint unsigned fixed_root(longint unsigned d);
    logic [69:0] rad;
    logic [69:0] rem;
    logic [69:0] acc;
    logic [69:0] trial;
    rad = 70'(d) << (2 * FracW);
    rem = '0;
    acc = '0;
    for (int i = 34; i >= 0; i--) begin
      rem = (rem << 2) | 70'((rad >> (2 * i)) & 70'd3);
      trial = (acc << 2) | 70'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        acc = (acc << 1) | 70'd1;
      end else begin
        acc = acc << 1;
      end
    end
    return longint'(acc);
  endfunction

  // clamp to the signed root range
  function automatic logic [RootW-1:0] clamp_root(longint v);
    longint hi;
    hi = (longint'(1) <<< (RootW - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[RootW-1:0];
  endfunction

  // expected status and roots of one coefficient set
  function automatic roots_t solve_roots(coef_set_t s);
    roots_t      res;
    longint      a;
    longint      b;
    longint      c;
    longint      one;
    longint      r1;
    longint      r2;
    longint      disc;
    longint      sq;
    a = s.a;
    b = s.b;
    c = s.c;
    one = longint'(1) <<< FracW;
    r1 = 0;
    r2 = 0;
    if (a == 0) begin
      if (b == 0) begin
        res.st = ST_NONE;
      end else begin
        res.st = ST_LIN;
        r1 = (-c * one) / b;
        r2 = r1;
      end
    end else if (a + c == b || a + b + c == 0) begin
      if (a + c == b) begin
        r1 = -one;
        r2 = (-c * one) / a;
      end else begin
        r1 = one;
        r2 = (c * one) / a;
      end
      res.st = (r1 == r2) ? ST_ONE : ST_TWO;
    end else begin
      disc = b * b - 4 * a * c;
      if (disc > 0) begin
        sq = longint'(fixed_root(longint'(disc)));
        res.st = ST_TWO;
        r1 = (-b * one + sq) / (2 * a);
        r2 = (-b * one - sq) / (2 * a);
      end else if (disc == 0) begin
        res.st = ST_ONE;
        r1 = (-b * one) / (2 * a);
        r2 = r1;
      end else begin
        res.st = ST_CPLX;
      end
    end
    res.r1 = clamp_root(r1);
    res.r2 = clamp_root(r2);
    return res;
  endfunction

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int pick_edge();
    case ($urandom_range(4))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 32767;
    endcase
  endfunction

  task automatic add_set(int a, int b, int c);
    coef_set_t s;
    s.a = a[CoefW-1:0];
    s.b = b[CoefW-1:0];
    s.c = c[CoefW-1:0];
    pending_sets.push_back(s);
  endtask

  // one random set, mostly shaped toward the special paths
  task automatic add_random_set();
    int a;
    int b;
    int c;
    int k;
    int m;
    int n;
    case ($urandom_range(9))
      3: begin
        a = 0;
        b = ($urandom_range(3) == 0) ? 0 : pick(-32768, 32767);
        c = pick(-32768, 32767);
      end
      4: begin
        a = pick(-16384, 16383);
        c = pick(-16384, 16383);
        b = a + c;
      end
      5: begin
        a = pick(-16384, 16383);
        c = pick(-16384, 16383);
        b = -(a + c);
      end
      6: begin
        k = pick(1, 8) * (($urandom_range(1) == 0) ? 1 : -1);
        m = pick(1, 40) * (($urandom_range(1) == 0) ? 1 : -1);
        n = pick(-40, 40);
        a = k * m * m;
        b = 2 * k * m * n;
        c = k * n * n;
      end
      7: begin
        a = pick(-8, 8);
        b = pick(-8, 8);
        c = pick(-8, 8);
      end
      8: begin
        a = pick_edge();
        b = pick_edge();
        c = pick_edge();
      end
      default: begin
        a = pick(-32768, 32767);
        b = pick(-32768, 32767);
        c = pick(-32768, 32767);
      end
    endcase
    add_set(a, b, c);
  endtask

  // stimulus
  initial begin
    err_cnt = 0;
    // directed: no solution, linear, shortcut tests, double root, complex, extremes
    add_set(0, 0, 5);
    add_set(0, 0, 0);
    add_set(0, 3, -7);
    add_set(0, -32768, 32767);
    add_set(0, 1, -32768);
    add_set(2, 5, 3);
    add_set(1, 2, 1);
    add_set(3, -1, -2);
    add_set(1, -2, 1);
    add_set(-5, 0, 5);
    add_set(1, 4, 4);
    add_set(1, 1, 1);
    add_set(-32768, -32768, -32768);
    add_set(32767, 32767, 32767);
    add_set(32767, -32768, 32767);
    add_set(-32768, 32767, 32767);
    add_set(1, -32768, -32768);
    add_set(-1, 32767, 1);
    add_set(32767, 3, -32768);
    add_set(7, -11, 2);
    for (int i = 0; i < 500; i++) add_random_set();
    wait (rst_ni);
    // pause the sender until every result is back
    wait (pending_sets.size() == 0 && !coef_if.valid && expected_roots.size() == 0);
    for (int i = 0; i < 600; i++) add_random_set();
    wait (pending_sets.size() == 0 && !coef_if.valid && expected_roots.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && expected_roots.size() == 0) begin
      $display("tb_quadratic_root_solver_core OK");
    end else begin
      $display("tb_quadratic_root_solver_core NOT OK");
    end
    $finish;
  end

  // sender: idles at random outside a quiet window
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_if.valid <= 1'b0;
      cycle_cnt <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (coef_if.valid && coef_if.ready) begin
        expected_roots.push_back(solve_roots(offered_set));
      end
      if (!coef_if.valid || coef_if.ready) begin
        if (pending_sets.size() != 0 &&
            ((cycle_cnt > QuietStart && cycle_cnt < QuietEnd) ||
             $urandom_range(99) >= 15)) begin
          offered_set = pending_sets.pop_front();
          coef_if.valid <= 1'b1;
          coef_if.coef_sq <= offered_set.a;
          coef_if.coef_lin <= offered_set.b;
          coef_if.coef_const <= offered_set.c;
        end else begin
          coef_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_if.ready <= 1'b0;
      results_seen <= 0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else begin
      if (root_if.valid && root_if.ready) begin
        results_seen <= results_seen + 1;
        if (expected_roots.size() == 0) begin
          $error("unexpected result transaction: status %0d", root_if.status);
          err_cnt++;
        end else begin
          roots_t exp_r;
          exp_r = expected_roots.pop_front();
          if (root_if.status !== exp_r.st) begin
            $error("status: expected %0d actual %0d", exp_r.st, root_if.status);
            err_cnt++;
          end
          if (root_if.root_first !== exp_r.r1) begin
            $error("root_first: expected %h actual %h", exp_r.r1, root_if.root_first);
            err_cnt++;
          end
          if (root_if.root_second !== exp_r.r2) begin
            $error("root_second: expected %h actual %h", exp_r.r2, root_if.root_second);
            err_cnt++;
          end
        end
      end
      if (!hold_done && results_seen == 250) begin
        hold_done <= 1'b1;
        hold_cnt <= HoldOffCycles;
        root_if.ready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        root_if.ready <= 1'b0;
      end else begin
        root_if.ready <= (cycle_cnt > QuietStart && cycle_cnt < QuietEnd) ||
                         $urandom_range(99) >= 15;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (coef_if.valid && coef_if.ready) || (root_if.valid && root_if.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WatchdogLimit) begin
      $display("tb_quadratic_root_solver_core NOT OK");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

endmodule
